[hw/rtl/lav_pkg.sv]
// Shared widths, row codes and rounding helper for the look-at view matrix core.
package lav_pkg;

  localparam int POS_W   = 32;   // Q16.16 coordinates
  localparam int NIN_W   = 34;   // signed vector component entering a normalizer
  localparam int MAG_W   = 34;   // magnitude of such a component
  localparam int MN_W    = 30;   // normalized magnitude, msb at bit 29
  localparam int NRM_MAX = 32;   // largest step of the leading-zero shifter
  localparam int NRM_STEPS = 6;  // steps 32, 16, 8, 4, 2, 1
  localparam int SQ_W    = 64;   // square-root working width
  localparam int SQ_N    = 32;   // one result bit per stage
  localparam int SQ_TOP  = 62;   // exponent of the first trial bit
  localparam int LEN_W   = 31;   // vector length
  localparam int REM_W   = 62;   // divider remainder
  localparam int DV_N    = 31;   // quotient bits, one per stage
  localparam int U_W     = 32;   // signed Q1.30 unit component
  localparam int FRAC_SH = 30;
  localparam int ROT_SH  = 14;
  localparam int PRD_W   = 64;
  localparam int DIF_W   = 65;
  localparam int NDOT_W  = 67;
  localparam int EL_W    = 48;
  localparam int RND_W   = 68;

  localparam logic [1:0] ROW_SIDE  = 2'd0;
  localparam logic [1:0] ROW_UP    = 2'd1;
  localparam logic [1:0] ROW_FRONT = 2'd2;

  // Shift right by k, rounding half away from zero.
  function automatic logic signed [RND_W-1:0] rnd_shr(input logic signed [RND_W-1:0] v,
                                                      input int unsigned k);
    logic [RND_W-1:0] m;
    m = v[RND_W-1] ? RND_W'(-v) : RND_W'(v);
    m = (m + (RND_W'(1) << (k - 1))) >> k;
    return v[RND_W-1] ? -$signed(m) : $signed(m);
  endfunction

endpackage

[hw/rtl/look_at_view_matrix_core.sv]
// Look-at view matrix core: Q16.16 camera and target in, three matrix rows out.
//
// Input channel: one beat carries camera position and target point (Q16.16).
// Output channel: three beats per input, rows side, up and negated front, each
// with three rotation entries and the translation entry in Q32.16. last_row
// marks the third beat. degenerate marks a target on the camera or a view
// direction along world up; the elements are then zero.
// Row 0 appears once the item has passed the difference stage, both
// normalizers and the row stages into the row serializer; rows 1 and 2
// follow as the receiver takes them. The three output beats per item hold
// the input; the datapath itself accepts a beat in every cycle while the
// serializer holds no item. The path length comes from the two normalizers,
// each a 32-stage square root followed by a 31-stage divider.
// Reset clears all valid bits; no item is in flight afterwards.
// A stalled receiver holds the current row; the whole pipeline freezes until
// the last row of the held item is taken, so nothing is lost or repeated.
module look_at_view_matrix_core
  import lav_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [POS_W-1:0] in_pos_z,
  input  logic signed [POS_W-1:0] in_tgt_x,
  input  logic signed [POS_W-1:0] in_tgt_y,
  input  logic signed [POS_W-1:0] in_tgt_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_row_index,
  output logic signed [EL_W-1:0]  out_elem_0,
  output logic signed [EL_W-1:0]  out_elem_1,
  output logic signed [EL_W-1:0]  out_elem_2,
  output logic signed [EL_W-1:0]  out_elem_3,
  output logic                    out_degenerate,
  output logic                    out_last_row
);

  localparam int SB1_W = 3 * POS_W;
  localparam int SB2_W = 1 + 3 * U_W + 3 * POS_W;

  logic adv;
  logic ser_v_r;
  logic [1:0] row_r;
  logic deg_r;
  logic signed [EL_W-1:0] el_r [3][4];

  // freeze everything while the held item still has rows to give
  assign adv      = !ser_v_r || (out_ready && (row_r == ROW_FRONT));
  assign in_ready = adv;

  // difference stage
  logic                    d_v_r;
  logic signed [NIN_W-1:0] d_r [3];
  logic [2:0][POS_W-1:0]   pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else if (adv) d_v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r[0] <= NIN_W'(in_tgt_x) - NIN_W'(in_pos_x);
      d_r[1] <= NIN_W'(in_tgt_y) - NIN_W'(in_pos_y);
      d_r[2] <= NIN_W'(in_tgt_z) - NIN_W'(in_pos_z);
      pos_r  <= {in_pos_z, in_pos_y, in_pos_x};
    end
  end

  // front
  logic                  n1_v, n1_ok;
  logic signed [U_W-1:0] n1_f [3];
  logic [SB1_W-1:0]      n1_sb;

  lav_norm #(.SB_W(SB1_W)) u_norm_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .in_v   (d_v_r),
    .in_c   (d_r),
    .in_sb  (pos_r),
    .out_v  (n1_v),
    .out_ok (n1_ok),
    .out_u  (n1_f),
    .out_sb (n1_sb)
  );

  // front x world up = (-f.z, 0, f.x)
  logic                    l_v_r;
  logic signed [NIN_W-1:0] l_sd_r [3];
  logic [SB2_W-1:0]        l_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) l_v_r <= 1'b0;
    else if (adv) l_v_r <= n1_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l_sd_r[0] <= -NIN_W'(n1_f[2]);
      l_sd_r[1] <= '0;
      l_sd_r[2] <= NIN_W'(n1_f[0]);
      l_sb_r    <= {n1_ok, n1_f[2], n1_f[1], n1_f[0], n1_sb};
    end
  end

  // side
  logic                  n2_v, n2_ok;
  logic signed [U_W-1:0] n2_s [3];
  logic [SB2_W-1:0]      n2_sb;

  lav_norm #(.SB_W(SB2_W)) u_norm_side (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .in_v   (l_v_r),
    .in_c   (l_sd_r),
    .in_sb  (l_sb_r),
    .out_v  (n2_v),
    .out_ok (n2_ok),
    .out_u  (n2_s),
    .out_sb (n2_sb)
  );

  logic                    rw_ok;
  logic signed [U_W-1:0]   rw_f [3];
  logic signed [POS_W-1:0] rw_pos [3];

  always_comb begin
    rw_ok = n2_ok && n2_sb[SB2_W-1];
    for (int i = 0; i < 3; i++) begin
      rw_f[i]   = n2_sb[SB1_W + i*U_W +: U_W];
      rw_pos[i] = n2_sb[i*POS_W +: POS_W];
    end
  end

  logic                   rs_v, rs_ok;
  logic signed [EL_W-1:0] rs_el [3][4];

  lav_rows u_rows (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .in_v   (n2_v),
    .in_ok  (rw_ok),
    .in_f   (rw_f),
    .in_s   (n2_s),
    .in_pos (rw_pos),
    .out_v  (rs_v),
    .out_ok (rs_ok),
    .out_el (rs_el)
  );

  // row serializer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      row_r   <= ROW_SIDE;
    end else if (adv) begin
      ser_v_r <= rs_v;
      row_r   <= ROW_SIDE;
    end else if (out_ready) begin
      row_r <= row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      deg_r <= !rs_ok;
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 4; i++) el_r[r][i] <= rs_ok ? rs_el[r][i] : '0;
      end
    end
  end

  assign out_valid      = ser_v_r;
  assign out_row_index  = row_r;
  assign out_elem_0     = el_r[row_r][0];
  assign out_elem_1     = el_r[row_r][1];
  assign out_elem_2     = el_r[row_r][2];
  assign out_elem_3     = el_r[row_r][3];
  assign out_degenerate = deg_r;
  assign out_last_row   = (row_r == ROW_FRONT);

endmodule

[hw/rtl/lav_norm.sv]
// Pipelined 3-vector normalizer: scale, square sum, bit-serial root, restoring divide.
module lav_norm
  import lav_pkg::*;
#(
  parameter int SB_W = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_v,
  input  logic signed [NIN_W-1:0] in_c [3],
  input  logic [SB_W-1:0]         in_sb,
  output logic                    out_v,
  output logic                    out_ok,
  output logic signed [U_W-1:0]   out_u [3],
  output logic [SB_W-1:0]         out_sb
);

  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][MN_W-1:0]  mn;
    logic                  nz;
    logic [SB_W-1:0]       sb;
  } carry_t;

  // stage 1: magnitudes and their maximum
  logic             s1_v_r;
  logic [2:0]       s1_neg_r, s1_neg_nxt;
  logic [MAG_W-1:0] s1_mag_r [3];
  logic [MAG_W-1:0] s1_mag_nxt [3];
  logic [MAG_W-1:0] s1_mx_r, s1_mx_nxt;
  logic [SB_W-1:0]  s1_sb_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_neg_nxt[i] = in_c[i][NIN_W-1];
      s1_mag_nxt[i] = s1_neg_nxt[i] ? MAG_W'(-in_c[i]) : MAG_W'(in_c[i]);
    end
    s1_mx_nxt = s1_mag_nxt[0];
    if (s1_mag_nxt[1] > s1_mx_nxt) s1_mx_nxt = s1_mag_nxt[1];
    if (s1_mag_nxt[2] > s1_mx_nxt) s1_mx_nxt = s1_mag_nxt[2];
  end

  // stage 2: bring the largest msb to the top, keep the upper bits
  logic   s2_v_r;
  carry_t s2_c_r, s2_c_nxt;

  always_comb begin
    logic [MAG_W-1:0] m [3];
    logic [MAG_W-1:0] x;
    x = s1_mx_r;
    m = s1_mag_r;
    for (int s = 0; s < NRM_STEPS; s++) begin
      if ((x >> (MAG_W - (NRM_MAX >> s))) == '0) begin
        x = x << (NRM_MAX >> s);
        for (int i = 0; i < 3; i++) m[i] = m[i] << (NRM_MAX >> s);
      end
    end
    for (int i = 0; i < 3; i++) s2_c_nxt.mn[i] = m[i][MAG_W-1 -: MN_W];
    s2_c_nxt.neg = s1_neg_r;
    s2_c_nxt.nz  = (s1_mx_r != '0);
    s2_c_nxt.sb  = s1_sb_r;
  end

  // stage 3: squares
  logic              s3_v_r;
  carry_t            s3_c_r;
  logic [2*MN_W-1:0] s3_sq_r [3];

  // root pipeline; entry 0 holds the square sum
  logic [SQ_N:0]   sq_v_r;
  logic [SQ_W-1:0] sq_x_r [SQ_N+1];
  logic [SQ_W-1:0] sq_r_r [SQ_N+1];
  carry_t          sq_c_r [SQ_N+1];
  logic [SQ_W-1:0] sq_x_nxt [SQ_N+1];
  logic [SQ_W-1:0] sq_r_nxt [SQ_N+1];

  always_comb begin
    logic [SQ_W-1:0] b;
    sq_x_nxt[0] = SQ_W'(s3_sq_r[0]) + SQ_W'(s3_sq_r[1]) + SQ_W'(s3_sq_r[2]);
    sq_r_nxt[0] = '0;
    for (int j = 1; j <= SQ_N; j++) begin
      b = SQ_W'(1) << (SQ_TOP - 2 * (j - 1));
      if (sq_x_r[j-1] >= sq_r_r[j-1] + b) begin
        sq_x_nxt[j] = sq_x_r[j-1] - (sq_r_r[j-1] + b);
        sq_r_nxt[j] = (sq_r_r[j-1] >> 1) + b;
      end else begin
        sq_x_nxt[j] = sq_x_r[j-1];
        sq_r_nxt[j] = sq_r_r[j-1] >> 1;
      end
    end
  end

  // divider pipeline; entry 0 holds the rounded dividend
  logic [DV_N:0]    dv_v_r;
  logic [REM_W-1:0] dv_rem_r [DV_N+1][3];
  logic [DV_N-1:0]  dv_q_r [DV_N+1][3];
  logic [LEN_W-1:0] dv_d_r [DV_N+1];
  carry_t           dv_c_r [DV_N+1];
  logic [REM_W-1:0] dv_rem_nxt [DV_N+1][3];
  logic [DV_N-1:0]  dv_q_nxt [DV_N+1][3];
  logic [LEN_W-1:0] len;

  assign len = sq_r_r[SQ_N][LEN_W-1:0];

  always_comb begin
    logic [REM_W-1:0] dsh;
    for (int i = 0; i < 3; i++) begin
      dv_rem_nxt[0][i] = (REM_W'(sq_c_r[SQ_N].mn[i]) << FRAC_SH) + REM_W'(len >> 1);
      dv_q_nxt[0][i]   = '0;
    end
    for (int k = 1; k <= DV_N; k++) begin
      dsh = REM_W'(dv_d_r[k-1]) << (DV_N - k);
      for (int i = 0; i < 3; i++) begin
        dv_rem_nxt[k][i] = dv_rem_r[k-1][i];
        dv_q_nxt[k][i]   = dv_q_r[k-1][i];
        if (dv_rem_r[k-1][i] >= dsh) begin
          dv_rem_nxt[k][i]          = dv_rem_r[k-1][i] - dsh;
          dv_q_nxt[k][i][DV_N - k]  = 1'b1;
        end
      end
    end
  end

  // output stage
  logic                  o_v_r;
  logic                  o_ok_r;
  logic signed [U_W-1:0] o_u_r [3];
  logic signed [U_W-1:0] o_u_nxt [3];
  logic [SB_W-1:0]       o_sb_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o_u_nxt[i] = dv_c_r[DV_N].neg[i] ? -$signed(U_W'(dv_q_r[DV_N][i]))
                                       : $signed(U_W'(dv_q_r[DV_N][i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      sq_v_r <= '0;
      dv_v_r <= '0;
      o_v_r  <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_v;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      sq_v_r <= {sq_v_r[SQ_N-1:0], s3_v_r};
      dv_v_r <= {dv_v_r[DV_N-1:0], sq_v_r[SQ_N]};
      o_v_r  <= dv_v_r[DV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_neg_r <= s1_neg_nxt;
      s1_mag_r <= s1_mag_nxt;
      s1_mx_r  <= s1_mx_nxt;
      s1_sb_r  <= in_sb;
      s2_c_r   <= s2_c_nxt;
      s3_c_r   <= s2_c_r;
      for (int i = 0; i < 3; i++) s3_sq_r[i] <= s2_c_r.mn[i] * s2_c_r.mn[i];
      sq_c_r[0] <= s3_c_r;
      for (int j = 0; j <= SQ_N; j++) begin
        sq_x_r[j] <= sq_x_nxt[j];
        sq_r_r[j] <= sq_r_nxt[j];
      end
      for (int j = 1; j <= SQ_N; j++) sq_c_r[j] <= sq_c_r[j-1];
      dv_d_r[0] <= len;
      dv_c_r[0] <= sq_c_r[SQ_N];
      for (int k = 0; k <= DV_N; k++) begin
        dv_rem_r[k] <= dv_rem_nxt[k];
        dv_q_r[k]   <= dv_q_nxt[k];
      end
      for (int k = 1; k <= DV_N; k++) begin
        dv_d_r[k] <= dv_d_r[k-1];
        dv_c_r[k] <= dv_c_r[k-1];
      end
      o_ok_r <= dv_c_r[DV_N].nz;
      o_u_r  <= o_u_nxt;
      o_sb_r <= dv_c_r[DV_N].sb;
    end
  end

  assign out_v  = o_v_r;
  assign out_ok = o_ok_r;
  assign out_u  = o_u_r;
  assign out_sb = o_sb_r;

endmodule

[hw/rtl/lav_rows.sv]
// Up vector, rounded rotation entries and translation column, six register stages.
module lav_rows
  import lav_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_v,
  input  logic                    in_ok,
  input  logic signed [U_W-1:0]   in_f [3],
  input  logic signed [U_W-1:0]   in_s [3],
  input  logic signed [POS_W-1:0] in_pos [3],
  output logic                    out_v,
  output logic                    out_ok,
  output logic signed [EL_W-1:0]  out_el [3][4]
);

  logic                    r1_v_r, r1_ok_r;
  logic signed [PRD_W-1:0] r1_p_r [6];
  logic signed [U_W-1:0]   r1_f_r [3];
  logic signed [U_W-1:0]   r1_s_r [3];
  logic signed [POS_W-1:0] r1_pos_r [3];

  logic                    r2_v_r, r2_ok_r;
  logic signed [DIF_W-1:0] r2_dif_r [3];
  logic signed [U_W-1:0]   r2_f_r [3];
  logic signed [U_W-1:0]   r2_s_r [3];
  logic signed [POS_W-1:0] r2_pos_r [3];

  logic                    r3_v_r, r3_ok_r;
  logic signed [U_W-1:0]   r3_row_r [3][3];
  logic signed [POS_W-1:0] r3_pos_r [3];

  logic                    r4_v_r, r4_ok_r;
  logic signed [EL_W-1:0]  r4_rot_r [3][3];
  logic signed [PRD_W-1:0] r4_pp_r [3][3];

  logic                     r5_v_r, r5_ok_r;
  logic signed [EL_W-1:0]   r5_rot_r [3][3];
  logic signed [NDOT_W-1:0] r5_nd_r [3];

  logic                    r6_v_r, r6_ok_r;
  logic signed [EL_W-1:0]  r6_el_r [3][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_v_r <= 1'b0;
      r2_v_r <= 1'b0;
      r3_v_r <= 1'b0;
      r4_v_r <= 1'b0;
      r5_v_r <= 1'b0;
      r6_v_r <= 1'b0;
    end else if (en) begin
      r1_v_r <= in_v;
      r2_v_r <= r1_v_r;
      r3_v_r <= r2_v_r;
      r4_v_r <= r3_v_r;
      r5_v_r <= r4_v_r;
      r6_v_r <= r5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // cross products of side and front
      r1_ok_r  <= in_ok;
      r1_p_r[0] <= in_s[1] * in_f[2];
      r1_p_r[1] <= in_s[2] * in_f[1];
      r1_p_r[2] <= in_s[2] * in_f[0];
      r1_p_r[3] <= in_s[0] * in_f[2];
      r1_p_r[4] <= in_s[0] * in_f[1];
      r1_p_r[5] <= in_s[1] * in_f[0];
      r1_f_r   <= in_f;
      r1_s_r   <= in_s;
      r1_pos_r <= in_pos;

      r2_ok_r     <= r1_ok_r;
      r2_dif_r[0] <= DIF_W'(r1_p_r[0]) - DIF_W'(r1_p_r[1]);
      r2_dif_r[1] <= DIF_W'(r1_p_r[2]) - DIF_W'(r1_p_r[3]);
      r2_dif_r[2] <= DIF_W'(r1_p_r[4]) - DIF_W'(r1_p_r[5]);
      r2_f_r      <= r1_f_r;
      r2_s_r      <= r1_s_r;
      r2_pos_r    <= r1_pos_r;

      r3_ok_r  <= r2_ok_r;
      r3_pos_r <= r2_pos_r;
      for (int i = 0; i < 3; i++) begin
        r3_row_r[ROW_SIDE][i]  <= r2_s_r[i];
        r3_row_r[ROW_UP][i]    <= U_W'(rnd_shr(RND_W'(r2_dif_r[i]), FRAC_SH));
        r3_row_r[ROW_FRONT][i] <= -r2_f_r[i];
      end

      r4_ok_r <= r3_ok_r;
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          r4_rot_r[r][i] <= EL_W'(rnd_shr(RND_W'(r3_row_r[r][i]), ROT_SH));
          r4_pp_r[r][i]  <= r3_row_r[r][i] * r3_pos_r[i];
        end
      end

      r5_ok_r  <= r4_ok_r;
      r5_rot_r <= r4_rot_r;
      for (int r = 0; r < 3; r++) begin
        r5_nd_r[r] <= -(NDOT_W'(r4_pp_r[r][0]) + NDOT_W'(r4_pp_r[r][1])
                        + NDOT_W'(r4_pp_r[r][2]));
      end

      r6_ok_r <= r5_ok_r;
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) r6_el_r[r][i] <= r5_rot_r[r][i];
        r6_el_r[r][3] <= EL_W'(rnd_shr(RND_W'(r5_nd_r[r]), FRAC_SH));
      end
    end
  end

  assign out_v  = r6_v_r;
  assign out_ok = r6_ok_r;
  assign out_el = r6_el_r;

endmodule

[hw/rtl/lav_checker.sv]
// Port-level checks on the row sequence of the look-at view matrix core.
module lav_checker
  import lav_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic signed [POS_W-1:0] in_pos_x,
  input logic signed [POS_W-1:0] in_pos_y,
  input logic signed [POS_W-1:0] in_pos_z,
  input logic signed [POS_W-1:0] in_tgt_x,
  input logic signed [POS_W-1:0] in_tgt_y,
  input logic signed [POS_W-1:0] in_tgt_z,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [1:0]              out_row_index,
  input logic signed [EL_W-1:0]  out_elem_0,
  input logic signed [EL_W-1:0]  out_elem_1,
  input logic signed [EL_W-1:0]  out_elem_2,
  input logic signed [EL_W-1:0]  out_elem_3,
  input logic                    out_degenerate,
  input logic                    out_last_row
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_index) && $stable(out_elem_3))
    else $error("stalled row changed");

  a_side_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_row_index == ROW_SIDE |=>
      out_valid && out_row_index == ROW_UP)
    else $error("up row did not follow side row");

  a_up_front: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_row_index == ROW_UP |=>
      out_valid && out_row_index == ROW_FRONT)
    else $error("front row did not follow up row");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_last_row == (out_row_index == ROW_FRONT))
    else $error("last_row flag off the front row");

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_elem_0 == '0 && out_elem_1 == '0 && out_elem_2 == '0 && out_elem_3 == '0)
    else $error("degenerate row with nonzero elements");

endmodule

bind look_at_view_matrix_core lav_checker u_lav_checker (.*);

[sim/look_at_view_matrix_core_tb.sv]
// Testbench for the look-at view matrix core: scoreboard-checked random and directed runs.
`timescale 1ns / 1ps

module look_at_view_matrix_core_tb;
  import lav_pkg::*;

  typedef struct {
    logic [1:0]             row;
    logic signed [EL_W-1:0] e0, e1, e2, e3;
    logic                   degen, last;
  } view_row_t;

  // Round half away from zero on a signed 128-bit value.
  function automatic logic signed [127:0] shr_round(input logic signed [127:0] v, input int k);
    logic [127:0] m;
    m = v[127] ? 128'(-v) : 128'(v);
    m = (m + (128'd1 << (k - 1))) >> k;
    return v[127] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit unit_vec(input longint d[3], output longint u[3]);
    logic [63:0] mag[3], mx, sum, len, q;
    bit neg[3];
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = d[i] < 0;
      mag[i] = neg[i] ? 64'(-d[i]) : 64'(d[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) return 0;
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 30) + (len >> 1)) / len;
      u[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  class view_scoreboard;
    view_row_t pending[$];
    int errors;
    int rows_seen;
    int degen_seen;

    function void note_input(input logic signed [31:0] p[3], input logic signed [31:0] t[3]);
      longint pos[3], d[3], f[3], sd[3], s[3], up[3], rw[3][3];
      logic signed [127:0] dot, e[4];
      bit ok;
      view_row_t r;
      for (int i = 0; i < 3; i++) begin
        pos[i] = p[i];
        d[i] = longint'(t[i]) - pos[i];
      end
      ok = unit_vec(d, f);
      if (ok) begin
        sd[0] = -f[2];
        sd[1] = 0;
        sd[2] = f[0];
        ok = unit_vec(sd, s);
      end
      if (ok) begin
        up[0] = shr_round(128'(s[1] * f[2]) - 128'(s[2] * f[1]), 30);
        up[1] = shr_round(128'(s[2] * f[0]) - 128'(s[0] * f[2]), 30);
        up[2] = shr_round(128'(s[0] * f[1]) - 128'(s[1] * f[0]), 30);
        for (int i = 0; i < 3; i++) begin
          rw[0][i] = s[i];
          rw[1][i] = up[i];
          rw[2][i] = -f[i];
        end
      end
      for (int k = 0; k < 3; k++) begin
        r.row = 2'(k);
        r.last = (k == 2);
        r.degen = !ok;
        e = '{default: 0};
        if (ok) begin
          dot = 0;
          for (int i = 0; i < 3; i++) begin
            e[i] = shr_round(128'(rw[k][i]), ROT_SH);
            dot = dot + 128'(rw[k][i]) * 128'(pos[i]);
          end
          e[3] = shr_round(-dot, FRAC_SH);
        end
        r.e0 = e[0][EL_W-1:0];
        r.e1 = e[1][EL_W-1:0];
        r.e2 = e[2][EL_W-1:0];
        r.e3 = e[3][EL_W-1:0];
        pending.push_back(r);
      end
    endfunction

    function void check_row(input view_row_t a);
      view_row_t x;
      rows_seen++;
      if (a.degen) degen_seen++;
      if (pending.size() == 0) begin
        $error("unexpected row beat: row_index %0d", a.row);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (a.row !== x.row) begin
        $error("row_index: expected %0d, got %0d", x.row, a.row); errors++;
      end
      if (a.e0 !== x.e0) begin
        $error("elem_0: expected %0d, got %0d", x.e0, a.e0); errors++;
      end
      if (a.e1 !== x.e1) begin
        $error("elem_1: expected %0d, got %0d", x.e1, a.e1); errors++;
      end
      if (a.e2 !== x.e2) begin
        $error("elem_2: expected %0d, got %0d", x.e2, a.e2); errors++;
      end
      if (a.e3 !== x.e3) begin
        $error("elem_3: expected %0d, got %0d", x.e3, a.e3); errors++;
      end
      if (a.degen !== x.degen) begin
        $error("degenerate: expected %0d, got %0d", x.degen, a.degen); errors++;
      end
      if (a.last !== x.last) begin
        $error("last_row: expected %0d, got %0d", x.last, a.last); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] in_pos_x = 0, in_pos_y = 0, in_pos_z = 0;
  logic signed [31:0] in_tgt_x = 0, in_tgt_y = 0, in_tgt_z = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] out_row_index;
  logic signed [EL_W-1:0] out_elem_0, out_elem_1, out_elem_2, out_elem_3;
  logic out_degenerate, out_last_row;

  view_scoreboard sb = new();
  int send_idle = 0;   // percent of cycles the sender holds back
  int recv_stall = 0;  // percent of cycles the receiver stalls
  bit hold_off = 0;
  int items_sent = 0;

  always #4 clk = ~clk;

  look_at_view_matrix_core uut (.*);

  // Receiver: decide ready on falling edges, sample on rising edges.
  always @(negedge clk) begin
    if (hold_off) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    view_row_t a;
    if (rst_n && out_valid && out_ready) begin
      a.row = out_row_index;
      a.e0 = out_elem_0;
      a.e1 = out_elem_1;
      a.e2 = out_elem_2;
      a.e3 = out_elem_3;
      a.degen = out_degenerate;
      a.last = out_last_row;
      sb.check_row(a);
    end
  end

  // Valid stays high after an accept so beats can follow back to back;
  // idle cycles and drain() drop it.
  task automatic send_view(input logic signed [31:0] p[3], input logic signed [31:0] t[3]);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_pos_x <= p[0];
    in_pos_y <= p[1];
    in_pos_z <= p[2];
    in_tgt_x <= t[0];
    in_tgt_y <= t[1];
    in_tgt_z <= t[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(p, t);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic idle(input int n);
    in_valid <= 0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed(32'($urandom_range(65535))) - 32768;
      2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom) >>> $urandom_range(20, 4);
    endcase
  endfunction

  task automatic send_random();
    logic signed [31:0] p[3], t[3];
    for (int i = 0; i < 3; i++) begin
      p[i] = rand_coord();
      t[i] = rand_coord();
    end
    case ($urandom_range(9))
      0: t = p;                       // target on camera
      1: begin                        // looking straight up or down
        t[0] = p[0];
        t[2] = p[2];
      end
      2: t[1] = p[1];                 // level view
      default: ;
    endcase
    send_view(p, t);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic signed [31:0] p[3], t[3];
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: extremes, degenerate cases, axis directions.
    p = '{0, 0, 0}; t = '{0, 0, 0}; send_view(p, t);
    p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}; t = p; send_view(p, t);
    p = '{0, 0, 0}; t = '{0, 32'sh10000, 0}; send_view(p, t);
    p = '{5, 32'sh80000000, -7}; t = '{5, 32'sh7fffffff, -7}; send_view(p, t);
    p = '{0, 0, 0}; t = '{0, 0, -32'sh10000}; send_view(p, t);
    p = '{0, 0, 0}; t = '{32'sh10000, 0, 0}; send_view(p, t);
    p = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
    t = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}; send_view(p, t);
    p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    t = '{32'sh80000000, 32'sh80000000, 32'sh80000000}; send_view(p, t);
    p = '{32'sh80000000, 0, 32'sh7fffffff}; t = '{32'sh7fffffff, 1, 32'sh80000000};
    send_view(p, t);
    p = '{0, 0, 0}; t = '{1, 0, 0}; send_view(p, t);
    p = '{0, 0, 0}; t = '{0, 0, 1}; send_view(p, t);
    p = '{32'sh30000, -32'sh20000, 32'sh50000}; t = '{0, 0, 0}; send_view(p, t);
    p = '{-1, -1, -1}; t = '{1, 1, 1}; send_view(p, t);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 75; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 75; end
        default: begin send_idle = 24; recv_stall = 24; end
      endcase
      repeat (30) send_random();
      drain();  // sender waits for every result
    end

    // Long receiver hold-off while the sender keeps offering beats; spread the
    // beats past the pipeline depth so the held output stalls the input.
    send_idle = 0;
    recv_stall = 0;
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      repeat (20) begin
        send_random();
        idle(10);
      end
    join
    drain();

    $display("Covered %0d views, %0d row beats (%0d degenerate), across idle and stall mixes.",
             items_sent, sb.rows_seen, sb.degen_seen);
    if (sb.errors == 0) $display("look_at_view_matrix_core_tb: PASS");
    else $display("look_at_view_matrix_core_tb: FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("look_at_view_matrix_core_tb: FAIL");
    $finish;
  end

endmodule

[look_at_view_matrix_core.f]
hw/rtl/lav_pkg.sv
hw/rtl/lav_norm.sv
hw/rtl/lav_rows.sv
hw/rtl/look_at_view_matrix_core.sv
hw/rtl/lav_checker.sv
sim/look_at_view_matrix_core_tb.sv
